// ----- rtl/core/accel_six_side_calibration_defines.svh -----
// assertion macros for the six side calibration block
`ifndef ACCEL_SIX_SIDE_CALIBRATION_DEFINES_SVH
`define ACCEL_SIX_SIDE_CALIBRATION_DEFINES_SVH

// implication checked on every rising clock edge outside reset
`define ASC_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

// next-cycle implication checked outside reset
`define ASC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");

`endif

// ----- rtl/core/asc_pkg.sv -----
// ----------------------------------------------------------------------------
// asc_pkg
// shared types and constants of the six side calibration block
// ----------------------------------------------------------------------------
`default_nettype none
package asc_pkg;

   typedef enum logic [2:0] {
      PH_IDLE     = 3'd0,
      PH_STARTED  = 3'd1,
      PH_REST     = 3'd2,
      PH_SAMPLING = 3'd3,
      PH_FINISHED = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_SAMPLE = 2'd0,
      KIND_START  = 2'd1,
      KIND_CANCEL = 2'd2
   } kind_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_EVAL,
      ST_DIVIDE,
      ST_RESPOND
   } ctrl_state_type;

   localparam logic [0:0] CSR_MIN_SAMPLES  = 1'b0;
   localparam logic [0:0] CSR_MIN_DWELL_MS = 1'b1;

   localparam int CSR_DATA_BITS = 20;
   localparam logic [19:0] MIN_SAMPLES_RESET = 20'd50;
   localparam logic [15:0] MIN_DWELL_RESET   = 16'd1000;

   // commands from controller to datapath
   typedef struct packed {
      logic load;
      logic eval;
      logic div_start;
      logic finish;
   } cmd_type;

   // status from datapath to controller
   typedef struct packed {
      logic need_div;
      logic div_done;
   } status_type;

endpackage
`default_nettype wire

// ----- rtl/core/accel_six_side_calibration.sv -----
// sequence: a request is loaded in ST_IDLE, evaluated in ST_EVAL and answered from ST_RESPOND;
// when a side completes, its mean first goes through the bit-serial divider in ST_DIVIDE
// one item at a time: the next request is taken only after the response transfers
// reset: synchronous active high, clears all calibration state, sets min_samples
// to 50 and min_dwell_ms to 1000
// ----------------------------------------------------------------------------
// accel_six_side_calibration
// six orientation accelerometer calibration sequencer
// ----------------------------------------------------------------------------
`default_nettype none
`include "accel_six_side_calibration_defines.svh"
module accel_six_side_calibration #(
   parameter int COUNT_BITS  = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [19:0]                   csr_data,
   input  wire logic                          req_valid,
   output logic                               req_ready,
   input  wire logic [1:0]                    req_kind,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  wire logic [31:0]                   req_time_ms,
   output logic                               rsp_valid,
   input  wire logic                          rsp_ready,
   output logic [2:0]                         rsp_phase,
   output logic [5:0]                         rsp_sides_done,
   output logic                               rsp_done_res,
   output logic signed [SAMPLE_BITS-1:0]      rsp_min_x,
   output logic signed [SAMPLE_BITS-1:0]      rsp_max_x,
   output logic signed [SAMPLE_BITS-1:0]      rsp_min_y,
   output logic signed [SAMPLE_BITS-1:0]      rsp_max_y,
   output logic signed [SAMPLE_BITS-1:0]      rsp_min_z,
   output logic signed [SAMPLE_BITS-1:0]      rsp_max_z
);

   asc_pkg::cmd_type    cmd;
   asc_pkg::status_type status;

   asc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   asc_datapath #(
      .COUNT_BITS  (COUNT_BITS),
      .SAMPLE_BITS (SAMPLE_BITS)
   ) u_datapath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .status         (status),
      .csr_write      (csr_write),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .req_kind       (req_kind),
      .req_accel_x    (req_accel_x),
      .req_accel_y    (req_accel_y),
      .req_accel_z    (req_accel_z),
      .req_time_ms    (req_time_ms),
      .rsp_phase      (rsp_phase),
      .rsp_sides_done (rsp_sides_done),
      .rsp_done_res   (rsp_done_res),
      .rsp_min_x      (rsp_min_x),
      .rsp_max_x      (rsp_max_x),
      .rsp_min_y      (rsp_min_y),
      .rsp_max_y      (rsp_max_y),
      .rsp_min_z      (rsp_min_z),
      .rsp_max_z      (rsp_max_z)
   );

   // no new transfer while a response is pending
   `ASC_ASSERT_IMP(a_ready_excl, clock, reset, rsp_valid, !req_ready)
   // no request is accepted back to back with another
   `ASC_ASSERT_NEXT(a_accept_busy, clock, reset, req_valid && req_ready, !req_ready)
   // done flag agrees with phase
   `ASC_ASSERT_IMP(a_done_phase, clock, reset, rsp_valid, rsp_done_res == (rsp_phase == asc_pkg::PH_IDLE || rsp_phase == asc_pkg::PH_FINISHED))

endmodule
`default_nettype wire

// ----- rtl/core/asc_ctrl.sv -----
// ----------------------------------------------------------------------------
// asc_ctrl
// controller sequencing load, evaluation, mean division and response
// ----------------------------------------------------------------------------
`default_nettype none
module asc_ctrl (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output asc_pkg::cmd_type            cmd,
   input  wire asc_pkg::status_type    status
);

   asc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= asc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      cmd       = '0;
      unique case (state_ff)
         asc_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = asc_pkg::ST_EVAL;
            end
         end
         asc_pkg::ST_EVAL: begin
            if (status.need_div) begin
               cmd.div_start = 1'b1;
               state_in      = asc_pkg::ST_DIVIDE;
            end else begin
               cmd.eval = 1'b1;
               state_in = asc_pkg::ST_RESPOND;
            end
         end
         asc_pkg::ST_DIVIDE: begin
            if (status.div_done) begin
               cmd.finish = 1'b1;
               state_in   = asc_pkg::ST_RESPOND;
            end
         end
         asc_pkg::ST_RESPOND: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = asc_pkg::ST_IDLE;
            end
         end
         default: state_in = asc_pkg::ST_IDLE;
      endcase
   end

endmodule
`default_nettype wire

// ----- rtl/core/asc_datapath.sv -----
// ----------------------------------------------------------------------------
// asc_datapath
// calibration state, side classing, accumulation and serial mean divider
// ----------------------------------------------------------------------------
`default_nettype none
module asc_datapath #(
   parameter int COUNT_BITS  = 20,
   parameter int SAMPLE_BITS = 16
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire asc_pkg::cmd_type              cmd,
   output asc_pkg::status_type                status,
   input  wire logic                          csr_write,
   input  wire logic                          csr_index,
   input  wire logic [19:0]                   csr_data,
   input  wire logic [1:0]                    req_kind,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_x,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_y,
   input  wire logic signed [SAMPLE_BITS-1:0] req_accel_z,
   input  wire logic [31:0]                   req_time_ms,
   output logic [2:0]                         rsp_phase,
   output logic [5:0]                         rsp_sides_done,
   output logic                               rsp_done_res,
   output logic signed [SAMPLE_BITS-1:0]      rsp_min_x,
   output logic signed [SAMPLE_BITS-1:0]      rsp_max_x,
   output logic signed [SAMPLE_BITS-1:0]      rsp_min_y,
   output logic signed [SAMPLE_BITS-1:0]      rsp_max_y,
   output logic signed [SAMPLE_BITS-1:0]      rsp_min_z,
   output logic signed [SAMPLE_BITS-1:0]      rsp_max_z
);

   localparam int SUM_BITS = SAMPLE_BITS + COUNT_BITS;
   localparam int MAG_BITS = SUM_BITS;
   localparam int STEP_BITS = $clog2(MAG_BITS + 1);
   localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

   logic [19:0] min_samples_ff;
   logic [15:0] min_dwell_ff;

   logic [1:0]                    kind_ff;
   logic signed [SAMPLE_BITS-1:0] ax_ff [3];
   logic [31:0]                   now_ff;

   asc_pkg::phase_type   phase_ff, phase_in;
   logic [2:0]           side_ff, side_in;
   logic [5:0]           mask_ff, mask_in;
   logic [31:0]          start_ff, start_in;
   logic [COUNT_BITS-1:0] count_ff, count_in;
   logic signed [SUM_BITS-1:0] sum_ff [3];
   logic signed [SUM_BITS-1:0] sum_in [3];
   logic signed [SAMPLE_BITS-1:0] mins_ff [3];
   logic signed [SAMPLE_BITS-1:0] maxs_ff [3];

   logic [MAG_BITS-1:0]   quo_ff, rem_ff;
   logic [COUNT_BITS-1:0] divisor_ff;
   logic [STEP_BITS-1:0]  step_ff;
   logic                  neg_ff;
   logic [1:0]            div_axis_ff;
   logic                  div_max_ff;
   logic                  div_busy_ff;

   // configuration
   always_ff @(posedge clock) begin
      if (reset) begin
         min_samples_ff <= asc_pkg::MIN_SAMPLES_RESET;
         min_dwell_ff   <= asc_pkg::MIN_DWELL_RESET;
      end else if (csr_write) begin
         unique case (csr_index)
            asc_pkg::CSR_MIN_SAMPLES:  min_samples_ff <= csr_data;
            asc_pkg::CSR_MIN_DWELL_MS: min_dwell_ff   <= csr_data[15:0];
            default: ;
         endcase
      end
   end

   // input capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff  <= req_kind;
         ax_ff[0] <= req_accel_x;
         ax_ff[1] <= req_accel_y;
         ax_ff[2] <= req_accel_z;
         now_ff   <= req_time_ms;
      end
   end

   // side classing
   logic [SAMPLE_BITS:0] mag [3];
   logic [1:0]           best;
   logic [SAMPLE_BITS:0] best_mag;
   logic [SAMPLE_BITS+2:0] mag_sum;
   logic [2:0]           cls;
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         mag[i] = ax_ff[i][SAMPLE_BITS-1]
                ? (SAMPLE_BITS+1)'(-$signed({ax_ff[i][SAMPLE_BITS-1], ax_ff[i]}))
                : {1'b0, ax_ff[i]};
      end
      best = 2'd0;
      best_mag = mag[0];
      if (mag[1] > best_mag) begin
         best = 2'd1;
         best_mag = mag[1];
      end
      if (mag[2] > best_mag) begin
         best = 2'd2;
         best_mag = mag[2];
      end
      mag_sum = (SAMPLE_BITS+3)'(mag[0]) + (SAMPLE_BITS+3)'(mag[1])
              + (SAMPLE_BITS+3)'(mag[2]);
      cls = 3'd0;
      if ({1'b0, best_mag, 1'b0} > mag_sum) begin
         cls = {best, 1'b0} + ((ax_ff[best] > 0) ? 3'd2 : 3'd1);
      end
   end

   // next state for one item (without division)
   logic        add_ok;
   logic [COUNT_BITS-1:0] count_add;
   logic signed [SUM_BITS-1:0] sum_add [3];
   logic        enough;
   logic [31:0] elapsed;
   asc_pkg::phase_type target;
   logic        do_enter;
   logic        need_div;
   logic [5:0]  mask_set;
   always_comb begin
      add_ok    = (count_ff != COUNT_MAX);
      count_add = add_ok ? count_ff + 1'b1 : count_ff;
      for (int i = 0; i < 3; i++)
         sum_add[i] = add_ok ? sum_ff[i] + SUM_BITS'(ax_ff[i]) : sum_ff[i];
      elapsed   = now_ff - start_ff;
      enough    = (32'(count_add) >= 32'(min_samples_ff)) && (elapsed >= 32'(min_dwell_ff));
      mask_set  = mask_ff | (6'd1 << (cls - 3'd1));
      target    = phase_ff;
      do_enter  = 1'b0;
      need_div  = 1'b0;
      count_in  = count_ff;
      side_in   = side_ff;
      mask_in   = mask_ff;
      for (int i = 0; i < 3; i++) sum_in[i] = sum_ff[i];
      case (kind_ff)
         asc_pkg::KIND_START: begin
            target = asc_pkg::PH_STARTED;
            do_enter = 1'b1;
         end
         asc_pkg::KIND_CANCEL: begin
            target = asc_pkg::PH_IDLE;
            do_enter = 1'b1;
         end
         asc_pkg::KIND_SAMPLE: begin
            case (phase_ff)
               asc_pkg::PH_STARTED: begin
                  target = asc_pkg::PH_REST;
                  do_enter = 1'b1;
               end
               asc_pkg::PH_REST: begin
                  if (side_ff == 3'd0) begin
                     side_in = cls;
                  end else if (side_ff == cls) begin
                     count_in = count_add;
                     for (int i = 0; i < 3; i++) sum_in[i] = sum_add[i];
                     if (enough) begin
                        target = asc_pkg::PH_SAMPLING;
                        do_enter = 1'b1;
                     end
                  end else begin
                     target = asc_pkg::PH_STARTED;
                     do_enter = 1'b1;
                  end
               end
               asc_pkg::PH_SAMPLING: begin
                  if (cls != 3'd0 && side_ff == cls) begin
                     count_in = count_add;
                     for (int i = 0; i < 3; i++) sum_in[i] = sum_add[i];
                     if (enough) begin
                        need_div = 1'b1;
                        mask_in  = mask_set;
                        target   = (mask_set == 6'h3f) ? asc_pkg::PH_FINISHED
                                                       : asc_pkg::PH_STARTED;
                        do_enter = 1'b1;
                     end
                  end else begin
                     target = asc_pkg::PH_STARTED;
                     do_enter = 1'b1;
                  end
               end
               asc_pkg::PH_IDLE, asc_pkg::PH_FINISHED: ;
               default: begin
                  target = asc_pkg::PH_IDLE;
                  do_enter = 1'b1;
               end
            endcase
         end
         default: ;
      endcase
      if (do_enter && target == phase_ff) do_enter = 1'b0;
      phase_in = phase_ff;
      start_in = start_ff;
      if (do_enter) begin
         phase_in = target;
         start_in = (target == asc_pkg::PH_IDLE) ? 32'd0 : now_ff;
         unique case (target)
            asc_pkg::PH_IDLE: begin
               count_in = '0;
               for (int i = 0; i < 3; i++) sum_in[i] = '0;
               mask_in = 6'd0;
            end
            asc_pkg::PH_STARTED, asc_pkg::PH_REST: begin
               count_in = '0;
               for (int i = 0; i < 3; i++) sum_in[i] = '0;
               side_in = 3'd0;
            end
            asc_pkg::PH_SAMPLING: begin
               count_in = '0;
               for (int i = 0; i < 3; i++) sum_in[i] = '0;
            end
            default: side_in = 3'd0;
         endcase
      end
   end

   assign status.need_div = need_div;
   assign status.div_done = div_busy_ff && (step_ff == '0);

   // state update; on division the accumulators are sampled by the divider first
   logic [1:0] div_axis;
   logic       clear_ext;
   assign div_axis  = 2'((cls - 3'd1) >> 1);
   assign clear_ext = do_enter && (target == asc_pkg::PH_IDLE);

   logic signed [SUM_BITS-1:0] dividend;
   assign dividend = sum_add[div_axis];

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= asc_pkg::PH_IDLE;
         side_ff  <= 3'd0;
         mask_ff  <= 6'd0;
         start_ff <= 32'd0;
         count_ff <= '0;
         for (int i = 0; i < 3; i++) begin
            sum_ff[i]  <= '0;
            mins_ff[i] <= '0;
            maxs_ff[i] <= '0;
         end
      end else if (cmd.eval || cmd.div_start) begin
         phase_ff <= phase_in;
         side_ff  <= side_in;
         mask_ff  <= mask_in;
         start_ff <= start_in;
         count_ff <= count_in;
         for (int i = 0; i < 3; i++) sum_ff[i] <= sum_in[i];
         if (clear_ext) begin
            for (int i = 0; i < 3; i++) begin
               mins_ff[i] <= '0;
               maxs_ff[i] <= '0;
            end
         end
      end else if (cmd.finish) begin
         if (div_max_ff)
            maxs_ff[div_axis_ff] <= neg_ff ? SAMPLE_BITS'(-quo_ff) : SAMPLE_BITS'(quo_ff);
         else
            mins_ff[div_axis_ff] <= neg_ff ? SAMPLE_BITS'(-quo_ff) : SAMPLE_BITS'(quo_ff);
      end
   end

   // restoring divider, one quotient bit per cycle
   logic [MAG_BITS:0] trial;
   assign trial = {rem_ff, quo_ff[MAG_BITS-1]} - (MAG_BITS+1)'(divisor_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         div_busy_ff <= 1'b0;
         step_ff     <= '0;
      end else if (cmd.div_start) begin
         div_busy_ff <= 1'b1;
         step_ff     <= STEP_BITS'(MAG_BITS);
         neg_ff      <= dividend[SUM_BITS-1];
         quo_ff      <= dividend[SUM_BITS-1] ? MAG_BITS'(-dividend) : MAG_BITS'(dividend);
         rem_ff      <= '0;
         divisor_ff  <= count_add;
         div_axis_ff <= div_axis;
         div_max_ff  <= ~cls[0];
      end else if (div_busy_ff) begin
         if (step_ff == '0) begin
            div_busy_ff <= 1'b0;
         end else begin
            step_ff <= step_ff - 1'b1;
            if (!trial[MAG_BITS]) begin
               rem_ff <= trial[MAG_BITS-1:0];
               quo_ff <= {quo_ff[MAG_BITS-2:0], 1'b1};
            end else begin
               rem_ff <= {rem_ff[MAG_BITS-2:0], quo_ff[MAG_BITS-1]};
               quo_ff <= {quo_ff[MAG_BITS-2:0], 1'b0};
            end
         end
      end
   end

   assign rsp_phase      = phase_ff;
   assign rsp_sides_done = mask_ff;
   assign rsp_done_res   = (phase_ff == asc_pkg::PH_IDLE) || (phase_ff == asc_pkg::PH_FINISHED);
   assign rsp_min_x      = mins_ff[0];
   assign rsp_max_x      = maxs_ff[0];
   assign rsp_min_y      = mins_ff[1];
   assign rsp_max_y      = maxs_ff[1];
   assign rsp_min_z      = mins_ff[2];
   assign rsp_max_z      = maxs_ff[2];

endmodule
`default_nettype wire
